/* design/tslr_pkg.sv */
// Shared types and constants of the two-level sequence reorder block.
package tslr_pkg;

  localparam int HEADER_WINDOW_DEF = 8;
  localparam int STREAM_SLOTS_DEF  = 4;
  localparam int FRAME_WINDOW_DEF  = 8;
  localparam int TAG_BITS_DEF      = 10;

  localparam int STREAM_W = 31;
  localparam int SEQ_W    = 32;
  localparam int TYPE_W   = 8;
  localparam int TAG_W    = 10;
  localparam int RES_MAX  = 41;
  localparam int CNT_W    = $clog2(RES_MAX + 1);

  localparam logic [TYPE_W-1:0] FT_HEADERS      = 8'h01;
  localparam logic [TYPE_W-1:0] FT_CONTINUATION = 8'h09;
  localparam logic [TYPE_W-1:0] FT_PUSH_PROMISE = 8'h05;
  localparam logic [SEQ_W-1:0]  SEQ_START       = 32'd1;

  typedef enum logic [1:0] {
    ST_RELEASED = 2'd0,
    ST_DUP      = 2'd1,
    ST_HELD     = 2'd2,
    ST_NO_ROOM  = 2'd3
  } status_t;

  // Commands from the controller to the datapath, one per controller state.
  typedef struct packed {
    logic load;
    logic hdr_eval;
    logic find;
    logic fdec;
    logic fpop;
    logic frel;
    logic chain_pop;
    logic flush;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic cur_hdr;
    logic hdr_inorder;
    logic frm_inorder;
    logic pop_valid;
    logic chain_more;
  } stat_t;

endpackage

/* design/tslr_ctrl.sv */
// Controller state machine of the two-level sequence reorder block.
module tslr_ctrl
  import tslr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_HDR   = 8'b00000010,
    S_FIND  = 8'b00000100,
    S_FDEC  = 8'b00001000,
    S_FPOP  = 8'b00010000,
    S_FREL  = 8'b00100000,
    S_AFTER = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_HDR;
        end
      end
      S_HDR: begin
        cmd.hdr_eval = 1'b1;
        if (!stat.cur_hdr || stat.hdr_inorder) begin
          state_next = S_FIND;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FIND: begin
        cmd.find   = 1'b1;
        state_next = S_FDEC;
      end
      S_FDEC: begin
        cmd.fdec   = 1'b1;
        state_next = stat.frm_inorder ? S_FPOP : S_AFTER;
      end
      S_FPOP: begin
        cmd.fpop   = 1'b1;
        state_next = stat.pop_valid ? S_FREL : S_AFTER;
      end
      S_FREL: begin
        cmd.frel   = 1'b1;
        state_next = S_FPOP;
      end
      S_AFTER: begin
        if (stat.chain_more) begin
          cmd.chain_pop = 1'b1;
          state_next    = S_FIND;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.flush  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

/* design/tslr_dp.sv */
// Datapath of the two-level sequence reorder block: windows, stream table, result queue.
module tslr_dp
  import tslr_pkg::*;
#(
  parameter int HEADER_WINDOW = HEADER_WINDOW_DEF,
  parameter int STREAM_SLOTS  = STREAM_SLOTS_DEF,
  parameter int FRAME_WINDOW  = FRAME_WINDOW_DEF,
  parameter int TAG_BITS      = TAG_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic [STREAM_W-1:0] stream_ident,
  input  logic [TYPE_W-1:0]   frame_type,
  input  logic [SEQ_W-1:0]    header_seq,
  input  logic [SEQ_W-1:0]    frame_seq,
  input  logic [TAG_W-1:0]    packet_tag,
  output logic                strobe,
  output logic [1:0]          status,
  output logic [TAG_W-1:0]    out_tag,
  output logic [STREAM_W-1:0] out_stream,
  output logic                last
);

  localparam int SW  = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam int HIW = (HEADER_WINDOW > 1) ? $clog2(HEADER_WINDOW) : 1;
  localparam int SIW = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;
  localparam int PW  = (FRAME_WINDOW > 1) ? $clog2(FRAME_WINDOW) : 1;
  localparam int AW  = (STREAM_SLOTS * FRAME_WINDOW > 1) ?
                       $clog2(STREAM_SLOTS * FRAME_WINDOW) : 1;

  // Working item.
  logic [STREAM_W-1:0] cur_stream;
  logic [SEQ_W-1:0]    cur_fseq;
  logic [SEQ_W-1:0]    cur_hseq;
  logic [SW-1:0]       cur_tag;
  logic                cur_hdr;
  logic                report;
  logic                chain;

  // Item popped from the header window, next in the chain.
  logic                chain_v;
  logic [STREAM_W-1:0] chain_stream;
  logic [SEQ_W-1:0]    chain_fseq;
  logic [SW-1:0]       chain_tag;

  // Header window.
  logic [SEQ_W-1:0]    header_next;
  logic [HEADER_WINDOW-1:0] hh_valid;
  logic [STREAM_W-1:0] hh_stream [HEADER_WINDOW];
  logic [SEQ_W-1:0]    hh_fseq   [HEADER_WINDOW];
  logic [SW-1:0]       hh_tag    [HEADER_WINDOW];

  // Stream table and frame windows.
  logic [STREAM_SLOTS-1:0] s_used;
  logic [STREAM_W-1:0] s_key  [STREAM_SLOTS];
  logic [SEQ_W-1:0]    s_next [STREAM_SLOTS];
  logic [PW-1:0]       s_head [STREAM_SLOTS];
  logic [FRAME_WINDOW-1:0] fvalid [STREAM_SLOTS];
  logic [SW-1:0]       tag_mem [STREAM_SLOTS * FRAME_WINDOW];
  logic [SW-1:0]       tag_rd;
  logic [SIW-1:0]      slot;
  logic                slot_ok;

  // Result queue: one pending result, so the final one can be marked.
  logic                pend_valid;
  logic [1:0]          pend_status;
  logic [TAG_W-1:0]    pend_tag;
  logic [STREAM_W-1:0] pend_stream;
  logic [CNT_W-1:0]    res_cnt;

  logic                in_hdr;
  logic                hit, free_ok;
  logic [SIW-1:0]      hit_idx, free_idx;
  logic [SEQ_W-1:0]    hd, hdm1, fd, fdm1, nx;
  logic [HIW-1:0]      hpos;
  logic [PW-1:0]       head, fpos;
  logic [PW:0]         psum;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic                h_lt, h_eq, h_far, f_lt, f_eq, f_far;
  logic                h_store, f_store;
  logic                emit_en;
  logic [1:0]          emit_st;
  logic [TAG_W-1:0]    emit_tag;
  logic [STREAM_W-1:0] emit_stream;

  assign in_hdr = (frame_type == FT_HEADERS) || (frame_type == FT_CONTINUATION) ||
                  (frame_type == FT_PUSH_PROMISE);

  // Header stage compare.
  assign h_lt  = header_next > cur_hseq;
  assign h_eq  = header_next == cur_hseq;
  assign hd    = cur_hseq - header_next;
  assign hdm1  = hd - SEQ_W'(1);
  assign h_far = hd > SEQ_W'(HEADER_WINDOW);
  assign hpos  = hdm1[HIW-1:0];

  // Stream lookup.
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = 0; i < STREAM_SLOTS; i++) begin
      if (!hit && s_used[i] && s_key[i] == cur_stream) begin
        hit     = 1'b1;
        hit_idx = SIW'(i);
      end
      if (!free_ok && !s_used[i]) begin
        free_ok  = 1'b1;
        free_idx = SIW'(i);
      end
    end
  end

  // Frame stage compare.
  assign nx    = s_next[slot];
  assign head  = s_head[slot];
  assign f_lt  = nx > cur_fseq;
  assign f_eq  = nx == cur_fseq;
  assign fd    = cur_fseq - nx;
  assign fdm1  = fd - SEQ_W'(1);
  assign f_far = fd > SEQ_W'(FRAME_WINDOW);
  assign psum  = {1'b0, head} + {1'b0, fdm1[PW-1:0]};
  assign fpos  = (psum >= (PW+1)'(FRAME_WINDOW)) ?
                 PW'(psum - (PW+1)'(FRAME_WINDOW)) : psum[PW-1:0];
  assign wr_addr = AW'(slot) * AW'(FRAME_WINDOW) + AW'(fpos);
  assign rd_addr = AW'(slot) * AW'(FRAME_WINDOW) + AW'(head);

  assign h_store = cmd.hdr_eval && cur_hdr && !h_lt && !h_eq && !h_far && !hh_valid[hpos];
  assign f_store = cmd.fdec && slot_ok && !f_lt && !f_eq && !f_far && !fvalid[slot][fpos];

  // Result produced in this cycle, if any.
  always_comb begin
    emit_en     = 1'b0;
    emit_st     = ST_RELEASED;
    emit_tag    = '0;
    emit_stream = '0;
    if (cmd.hdr_eval && cur_hdr && !h_eq) begin
      emit_en = 1'b1;
      if (h_lt) begin
        emit_st = ST_DUP;
      end else if (h_far) begin
        emit_st = ST_NO_ROOM;
      end else if (hh_valid[hpos]) begin
        emit_st = ST_DUP;
      end else begin
        emit_st = ST_HELD;
      end
    end else if (cmd.fdec) begin
      if (slot_ok && f_eq) begin
        emit_en     = 1'b1;
        emit_st     = ST_RELEASED;
        emit_tag    = TAG_W'(cur_tag);
        emit_stream = cur_stream;
      end else begin
        emit_en = report;
        if (!slot_ok || (!f_lt && f_far)) begin
          emit_st = ST_NO_ROOM;
        end else if (f_lt || fvalid[slot][fpos]) begin
          emit_st = ST_DUP;
        end else begin
          emit_st = ST_HELD;
        end
      end
    end else if (cmd.frel) begin
      emit_en     = 1'b1;
      emit_st     = ST_RELEASED;
      emit_tag    = TAG_W'(tag_rd);
      emit_stream = cur_stream;
    end
  end

  assign stat.cur_hdr     = cur_hdr;
  assign stat.hdr_inorder = cur_hdr && h_eq;
  assign stat.frm_inorder = slot_ok && f_eq;
  assign stat.pop_valid   = fvalid[slot][head];
  assign stat.chain_more  = chain && chain_v;

  // Working item and header window.
  always_ff @(posedge clk) begin
    if (rst) begin
      header_next <= SEQ_START;
      hh_valid    <= '0;
      chain       <= 1'b0;
      chain_v     <= 1'b0;
    end else begin
      if (cmd.load) begin
        cur_stream <= stream_ident;
        cur_fseq   <= frame_seq;
        cur_hseq   <= header_seq;
        cur_tag    <= packet_tag[SW-1:0];
        cur_hdr    <= in_hdr;
        report     <= 1'b1;
        chain      <= 1'b0;
      end
      if ((cmd.hdr_eval && cur_hdr && h_eq) || cmd.chain_pop) begin
        header_next  <= header_next + SEQ_W'(1);
        chain_v      <= hh_valid[0];
        chain_stream <= hh_stream[0];
        chain_fseq   <= hh_fseq[0];
        chain_tag    <= hh_tag[0];
        for (int j = 0; j + 1 < HEADER_WINDOW; j++) begin
          hh_valid[j]  <= hh_valid[j+1];
          hh_stream[j] <= hh_stream[j+1];
          hh_fseq[j]   <= hh_fseq[j+1];
          hh_tag[j]    <= hh_tag[j+1];
        end
        hh_valid[HEADER_WINDOW-1] <= 1'b0;
        if (cmd.chain_pop) begin
          cur_stream <= chain_stream;
          cur_fseq   <= chain_fseq;
          cur_tag    <= chain_tag;
          report     <= 1'b0;
        end else begin
          chain <= 1'b1;
        end
      end
      if (h_store) begin
        hh_valid[hpos]  <= 1'b1;
        hh_stream[hpos] <= cur_stream;
        hh_fseq[hpos]   <= cur_fseq;
        hh_tag[hpos]    <= cur_tag;
      end
    end
  end

  // Stream table and frame windows.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_used  <= '0;
      slot_ok <= 1'b0;
      slot    <= '0;
    end else begin
      if (cmd.find) begin
        if (hit) begin
          slot    <= hit_idx;
          slot_ok <= 1'b1;
        end else if (free_ok) begin
          slot             <= free_idx;
          slot_ok          <= 1'b1;
          s_used[free_idx] <= 1'b1;
          s_key[free_idx]  <= cur_stream;
          s_next[free_idx] <= SEQ_START;
          s_head[free_idx] <= '0;
          fvalid[free_idx] <= '0;
        end else begin
          slot_ok <= 1'b0;
        end
      end
      if (f_store) begin
        fvalid[slot][fpos] <= 1'b1;
      end
      if (cmd.fpop) begin
        fvalid[slot][head] <= 1'b0;
        s_next[slot]       <= nx + SEQ_W'(1);
        s_head[slot]       <= (head == PW'(FRAME_WINDOW - 1)) ? '0 : head + PW'(1);
      end
    end
  end

  // Held frame tags.
  always_ff @(posedge clk) begin
    if (f_store) begin
      tag_mem[wr_addr] <= cur_tag;
    end
    tag_rd <= tag_mem[rd_addr];
  end

  // Result queue and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      res_cnt    <= '0;
      strobe     <= 1'b0;
    end else begin
      if (cmd.load) begin
        res_cnt <= '0;
      end
      if (cmd.flush) begin
        strobe     <= pend_valid;
        status     <= pend_status;
        out_tag    <= pend_tag;
        out_stream <= pend_stream;
        last       <= 1'b1;
        pend_valid <= 1'b0;
      end else if (emit_en && res_cnt < CNT_W'(RES_MAX)) begin
        res_cnt     <= res_cnt + CNT_W'(1);
        pend_valid  <= 1'b1;
        pend_status <= emit_st;
        pend_tag    <= emit_tag;
        pend_stream <= emit_stream;
        strobe      <= pend_valid;
        status      <= pend_status;
        out_tag     <= pend_tag;
        out_stream  <= pend_stream;
        last        <= 1'b0;
      end else begin
        strobe <= 1'b0;
      end
    end
  end

endmodule

/* design/two_level_sequence_reorder.sv */
// Top level of the two-level sequence reorder block.
//
//  Channel   Handshake        Payload
//  -------   --------------   ---------------------------------------------------
//  input     start / busy     stream_ident, frame_type, header_seq, frame_seq,
//                             packet_tag
//  result    strobe           status, out_tag, out_stream, last
//
// An item is taken at a clock edge where start is high and busy is low. It
// then runs through the controller: header check, stream lookup, frame check,
// and a pop state followed by a release state for each held successor, walking
// each window entry by entry. Held header items that become in order are
// chained through the same stream lookup and frame check. No new item is
// taken until the controller is back in idle.
// Results leave at most one per cycle behind a one-deep pending register, so
// the final one can carry last; it appears in the cycle after the controller
// finishes. The receiver cannot stall and strobe marks each result.
// Reset is synchronous and active high; it empties both windows and the stream
// table and sets the expected header number to one.
module two_level_sequence_reorder
  import tslr_pkg::*;
#(
  parameter int HEADER_WINDOW = HEADER_WINDOW_DEF,
  parameter int STREAM_SLOTS  = STREAM_SLOTS_DEF,
  parameter int FRAME_WINDOW  = FRAME_WINDOW_DEF,
  parameter int TAG_BITS      = TAG_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [STREAM_W-1:0] stream_ident,
  input  logic [TYPE_W-1:0]   frame_type,
  input  logic [SEQ_W-1:0]    header_seq,
  input  logic [SEQ_W-1:0]    frame_seq,
  input  logic [TAG_W-1:0]    packet_tag,
  output logic                strobe,
  output logic [1:0]          status,
  output logic [TAG_W-1:0]    out_tag,
  output logic [STREAM_W-1:0] out_stream,
  output logic                last
);

  cmd_t  cmd;
  stat_t stat;

  // The controller sequences the stages; it only sees the status flags.
  tslr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // The datapath holds the windows, the stream table and the result register.
  tslr_dp #(
    .HEADER_WINDOW (HEADER_WINDOW),
    .STREAM_SLOTS  (STREAM_SLOTS),
    .FRAME_WINDOW  (FRAME_WINDOW),
    .TAG_BITS      (TAG_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .stream_ident (stream_ident),
    .frame_type   (frame_type),
    .header_seq   (header_seq),
    .frame_seq    (frame_seq),
    .packet_tag   (packet_tag),
    .strobe       (strobe),
    .status       (status),
    .out_tag      (out_tag),
    .out_stream   (out_stream),
    .last         (last)
  );

endmodule
